@@ rtl/set_assoc_lru_cache_model_assert.svh @@
// Assertion macros shared by the cache model RTL.
// Depends on nothing; users provide clk and rst in scope.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SALC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/salc_pkg.sv @@
// Shared types and constants for the set-associative LRU cache model.
// Depends on nothing.
package salc_pkg;

  localparam int TAG_W    = 64;
  localparam int WAYS_W   = 4;
  localparam int TOTAL_W  = 32;
  localparam int STAMP_W  = 64;
  localparam int AGE_W    = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_WAY_COUNT  = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

  typedef struct packed {
    logic [1:0]         first_outcome;
    logic               second_hit;
    logic [TOTAL_W-1:0] hit_total;
    logic [TOTAL_W-1:0] miss_total;
    logic [TOTAL_W-1:0] evict_total;
  } res_t;

endpackage

@@ rtl/set_assoc_lru_cache_model.sv @@
// Top level of the set-associative LRU cache model: front end, request queue,
// back end and result queue. Depends on salc_pkg, salc_fifo, salc_front, salc_back.
//
//   channel   handshake             payload
//   request   push / full           req_type, addr
//   result    pop / empty           first_outcome, second_hit, hit/miss/evict totals
//   config    cfg_we                cfg_idx, cfg_data
//
// A hit or a fill passes the compare and write states of the back end; an eviction
// with more than one way also scans the set for the oldest way, one way per cycle.
// After reset the tag store is cleared one set per cycle, and full stays high until
// the clear is done.
// Ages are kept as access stamps against a request count, so no sweep is needed.
// Requests and results each pass a two-entry queue, so either side may stall.
module set_assoc_lru_cache_model #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [3:0]  cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [63:0] addr,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  first_outcome,
  output logic        second_hit,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total,
  output logic [31:0] evict_total
);

  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W  = (SB_MAX > 0) ? SB_MAX : 1;
  localparam int ITEM_W = 1 + salc_pkg::WAYS_W + SET_W + salc_pkg::TAG_W;

  logic              clearing;
  logic              q_full;
  logic              q_push;
  logic [ITEM_W-1:0] q_din;
  logic              q_empty;
  logic              q_pop;
  logic [ITEM_W-1:0] q_dout;
  logic              res_full;
  logic              res_push;
  salc_pkg::res_t    res_din;
  salc_pkg::res_t    res_dout;

  salc_front #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .push     (push),
    .req_type (req_type),
    .addr     (addr),
    .full     (full),
    .clearing (clearing),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_din)
  );

  salc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (salc_pkg::QUEUE_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  salc_back #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_dout),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_din),
    .clearing (clearing)
  );

  salc_fifo #(
    .WIDTH ($bits(salc_pkg::res_t)),
    .DEPTH (salc_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_din),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign first_outcome = res_dout.first_outcome;
  assign second_hit    = res_dout.second_hit;
  assign hit_total     = res_dout.hit_total;
  assign miss_total    = res_dout.miss_total;
  assign evict_total   = res_dout.evict_total;

endmodule

@@ rtl/salc_fifo.sv @@
// Small first-in first-out queue used between the cache model stages.
// Depends on nothing.
module salc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/salc_front.sv @@
// Front end: configuration registers and splitting of each request into set and tag.
// Depends on salc_pkg.
module salc_front #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8,
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1,
  localparam int SET_W  = (SB_MAX > 0) ? SB_MAX : 1,
  localparam int ITEM_W = 1 + salc_pkg::WAYS_W + SET_W + salc_pkg::TAG_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [3:0]        cfg_data,
  input  logic              push,
  input  logic [1:0]        req_type,
  input  logic [63:0]       addr,
  output logic              full,
  input  logic              clearing,
  input  logic              q_full,
  output logic              q_push,
  output logic [ITEM_W-1:0] q_data
);

  logic [2:0]                   set_bits;
  logic [3:0]                   way_count;
  logic [3:0]                   block_bits;
  logic [2:0]                   sb;
  logic [4:0]                   shamt;
  logic [3:0]                   ways;
  logic [63:0]                  addr_blk;
  logic [SET_W-1:0]             set_mask;
  logic [SET_W-1:0]             set_idx;
  logic [salc_pkg::TAG_W-1:0]   tag;
  logic                         is_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits   <= 3'd0;
      way_count  <= 4'd1;
      block_bits <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        salc_pkg::CFG_SET_BITS:   set_bits   <= cfg_data[2:0];
        salc_pkg::CFG_WAY_COUNT:  way_count  <= cfg_data;
        salc_pkg::CFG_BLOCK_BITS: block_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sb = (int'(set_bits) > SB_MAX) ? 3'(SB_MAX) : set_bits;
    if (way_count == 4'd0) begin
      ways = 4'd1;
    end else if (int'(way_count) > MAX_WAYS) begin
      ways = 4'(MAX_WAYS);
    end else begin
      ways = way_count;
    end
    shamt    = 5'(sb) + 5'(block_bits);
    addr_blk = addr >> block_bits;
    set_mask = ~({SET_W{1'b1}} << sb);
    set_idx  = addr_blk[SET_W-1:0] & set_mask;
    tag      = addr >> shamt;
    is_mod   = (req_type == salc_pkg::REQ_MODIFY);
  end

  assign full   = q_full || clearing;
  assign q_push = push && !full;
  assign q_data = {is_mod, ways, set_idx, tag};

endmodule

@@ rtl/salc_back.sv @@
// Back end: tag store, hit and replacement decision, LRU ages and running totals.
// Depends on salc_pkg and set_assoc_lru_cache_model_assert.svh.
`include "set_assoc_lru_cache_model_assert.svh"

module salc_back #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8,
  localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1,
  localparam int SET_W  = (SB_MAX > 0) ? SB_MAX : 1,
  localparam int ITEM_W = 1 + salc_pkg::WAYS_W + SET_W + salc_pkg::TAG_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  logic [ITEM_W-1:0] q_data,
  output logic              q_pop,
  input  logic              res_full,
  output logic              res_push,
  output salc_pkg::res_t    res_data,
  output logic              clearing
);

  localparam int NUM_SETS = 1 << SB_MAX;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W    = salc_pkg::TAG_W;
  localparam int STAMP_W  = salc_pkg::STAMP_W;
  localparam int AGE_W    = salc_pkg::AGE_W;
  localparam int TOTAL_W  = salc_pkg::TOTAL_W;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_CMP   = 5'b00100,
    ST_VIC   = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  function automatic logic [AGE_W-1:0] sat_age(logic [STAMP_W-1:0] cur,
                                               logic [STAMP_W-1:0] stamp);
    logic [STAMP_W-1:0] diff;
    diff = cur - stamp;
    return (|diff[STAMP_W-1:AGE_W]) ? '1 : diff[AGE_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] v, logic en);
    return (en && v != '1) ? v + 1'b1 : v;
  endfunction

  line_t [MAX_WAYS-1:0] mem [NUM_SETS];
  line_t [MAX_WAYS-1:0] rd_row;
  line_t [MAX_WAYS-1:0] row;
  line_t [MAX_WAYS-1:0] row_next;
  line_t [MAX_WAYS-1:0] mem_wd;
  logic                 mem_we;
  logic [SET_W-1:0]     mem_wa;

  state_t                      state;
  logic [SET_W-1:0]            clr_idx;
  logic [STAMP_W-1:0]          now;
  logic [TOTAL_W-1:0]          hits;
  logic [TOTAL_W-1:0]          misses;
  logic [TOTAL_W-1:0]          evicts;
  logic [TAG_W-1:0]            it_tag;
  logic [SET_W-1:0]            it_set;
  logic [salc_pkg::WAYS_W-1:0] it_ways;
  logic                        it_mod;
  logic [1:0]                  outcome;
  logic [WAY_W-1:0]            vic_w;
  logic [WAY_W-1:0]            best_w;
  logic [AGE_W-1:0]            best_age;

  logic                        hit_any;
  logic                        inv_any;
  logic [WAY_W-1:0]            hit_w;
  logic [WAY_W-1:0]            inv_w;
  logic [AGE_W-1:0]            age0;
  logic [AGE_W-1:0]            age_v;
  logic                        vic_bigger;
  logic [WAY_W-1:0]            vic_win;
  logic                        vic_last;
  logic [TOTAL_W-1:0]          hits_first;
  logic [TOTAL_W-1:0]          hits_next;
  logic [TOTAL_W-1:0]          misses_next;
  logic [TOTAL_W-1:0]          evicts_next;
  logic [SET_W-1:0]            q_set;

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && !q_empty && !res_full;
  assign q_set    = q_data[TAG_W +: SET_W];

  assign mem_we = (state == ST_CLEAR) || (state == ST_WRITE);
  assign mem_wa = (state == ST_CLEAR) ? clr_idx : it_set;
  assign mem_wd = (state == ST_CLEAR) ? '0 : row;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_row <= mem[q_set];
    end
  end

  always_comb begin
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_w   = '0;
    inv_w   = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (i < int'(it_ways)) begin
        if (rd_row[i].valid && rd_row[i].tag == it_tag) begin
          hit_any = 1'b1;
          hit_w   = WAY_W'(i);
        end
        if (!rd_row[i].valid) begin
          inv_any = 1'b1;
          inv_w   = WAY_W'(i);
        end
      end
    end
  end

  always_comb begin
    age0       = sat_age(now, rd_row[0].stamp);
    age_v      = sat_age(now, row[vic_w].stamp);
    vic_bigger = (age_v > best_age);
    vic_win    = vic_bigger ? vic_w : best_w;
    vic_last   = (int'(vic_w) == int'(it_ways) - 1);
  end

  always_comb begin
    row_next = row;
    case (state)
      ST_CMP: begin
        row_next = rd_row;
        if (hit_any) begin
          row_next[hit_w].stamp = now;
        end else if (inv_any) begin
          row_next[inv_w].valid = 1'b1;
          row_next[inv_w].tag   = it_tag;
          row_next[inv_w].stamp = now;
        end else if (it_ways == 4'd1) begin
          row_next[0].tag   = it_tag;
          row_next[0].stamp = now;
        end
      end
      ST_VIC: begin
        if (vic_last) begin
          row_next[vic_win].tag   = it_tag;
          row_next[vic_win].stamp = now;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    row <= row_next;
  end

  always_comb begin
    hits_first  = sat_inc(hits, outcome == salc_pkg::OUT_HIT);
    hits_next   = sat_inc(hits_first, it_mod);
    misses_next = sat_inc(misses, outcome != salc_pkg::OUT_HIT);
    evicts_next = sat_inc(evicts, outcome == salc_pkg::OUT_EVICT);
  end

  assign res_push               = (state == ST_WRITE);
  assign res_data.first_outcome = outcome;
  assign res_data.second_hit    = it_mod;
  assign res_data.hit_total     = hits_next;
  assign res_data.miss_total    = misses_next;
  assign res_data.evict_total   = evicts_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      now     <= '0;
      hits    <= '0;
      misses  <= '0;
      evicts  <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_idx == SET_W'(NUM_SETS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            it_tag  <= q_data[TAG_W-1:0];
            it_set  <= q_set;
            it_ways <= q_data[TAG_W + SET_W +: salc_pkg::WAYS_W];
            it_mod  <= q_data[ITEM_W-1];
            state   <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (hit_any) begin
            outcome <= salc_pkg::OUT_HIT;
            state   <= ST_WRITE;
          end else if (inv_any) begin
            outcome <= salc_pkg::OUT_FILL;
            state   <= ST_WRITE;
          end else begin
            outcome  <= salc_pkg::OUT_EVICT;
            best_w   <= '0;
            best_age <= age0;
            vic_w    <= WAY_W'(1);
            if (it_ways == 4'd1) begin
              state <= ST_WRITE;
            end else begin
              state <= ST_VIC;
            end
          end
        end
        ST_VIC: begin
          if (vic_last) begin
            state <= ST_WRITE;
          end else begin
            best_w   <= vic_win;
            best_age <= vic_bigger ? age_v : best_age;
            vic_w    <= vic_w + 1'b1;
          end
        end
        ST_WRITE: begin
          hits   <= hits_next;
          misses <= misses_next;
          evicts <= evicts_next;
          now    <= now + 1'b1;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  `SALC_CHECK_SAME(a_result_room, res_push, !res_full, "result written into a full queue")
  `SALC_CHECK_NEXT(a_step_count, state == ST_WRITE, now == $past(now) + 64'd1, "step count slipped")
  `SALC_CHECK_SAME(a_victim_range, state == ST_VIC, int'(vic_w) < int'(it_ways), "victim out of range")

endmodule
